>>> rtl/core/tmrld_pkg.sv
// Shared types, codes and helpers for the tile-map run-length decoder.
`default_nettype none
package tmrld_pkg;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);

	// result kinds
	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_FLOOR   = 3'd1;
	localparam logic [2:0] KIND_RECORD  = 3'd2;
	localparam logic [2:0] KIND_ESTART  = 3'd3;
	localparam logic [2:0] KIND_EBYTE   = 3'd4;
	localparam logic [2:0] KIND_END     = 3'd5;

	// end status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FORMAT = 2'd1;
	localparam logic [1:0] STAT_SIZE   = 2'd2;

	// parser phases
	localparam logic [3:0] PH_HEADER  = 4'd0;
	localparam logic [3:0] PH_FLOOR   = 4'd1;
	localparam logic [3:0] PH_BHEAD   = 4'd2;
	localparam logic [3:0] PH_DETAIL  = 4'd3;
	localparam logic [3:0] PH_CENTER  = 4'd4;
	localparam logic [3:0] PH_ELEN    = 4'd5;
	localparam logic [3:0] PH_PAYLOAD = 4'd6;
	localparam logic [3:0] PH_COUNT   = 4'd7;
	localparam logic [3:0] PH_DONE    = 4'd8;

	localparam logic [7:0] FLAG_ALLOWED = 8'h05;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] pos;
		logic [8:0]  cnt;
		logic [15:0] fw;
		logic [15:0] sw;
		logic [2:0]  flags;
		logic [7:0]  small_v;
		logic [7:0]  fdet;
		logic [7:0]  odet;
		logic [31:0] wide;
		logic        center;
		logic [1:0]  status;
	} item_t;

	// one queue entry: the results caused by one byte
	typedef struct packed {
		logic  two;
		item_t r0;
		item_t r1;
	} event_t;

	function automatic item_t mk_item(input logic [2:0] kind);
		item_t it;
		it = '0;
		it.kind = kind;
		return it;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/tmrld_in_if.sv
// Byte stream channel.
`default_nettype none
interface tmrld_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;
	modport source (output valid, byte_value, last_byte, input ready);
	modport sink (input valid, byte_value, last_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tmrld_out_if.sv
// Decoded result channel.
`default_nettype none
interface tmrld_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  record_kind;
	logic [31:0] tile_position;
	logic [8:0]  run_count;
	logic [15:0] first_word;
	logic [15:0] second_word;
	logic [2:0]  tile_flags;
	logic [7:0]  small_value;
	logic [7:0]  floor_detail;
	logic [7:0]  overlay_detail;
	logic [31:0] wide_value;
	logic        entity_marked;
	logic [1:0]  frame_status;
	modport source (output valid, record_kind, tile_position, run_count, first_word,
		second_word, tile_flags, small_value, floor_detail, overlay_detail, wide_value,
		entity_marked, frame_status, input ready);
	modport sink (input valid, record_kind, tile_position, run_count, first_word,
		second_word, tile_flags, small_value, floor_detail, overlay_detail, wide_value,
		entity_marked, frame_status, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tmrld_front.sv
// Byte parser: classifies each byte and produces the results it causes.
`default_nettype none
module tmrld_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	tmrld_in_if.sink              stream,
	input  wire logic             space,
	output tmrld_pkg::event_t     ev,
	output logic                  ev_push
);
	import tmrld_pkg::*;

	logic [3:0]  phase_q, phase_n;
	logic [2:0]  idx_q, idx_n;
	logic [15:0] width_q, width_n, height_q, height_n;
	logic [31:0] total_q, total_n, cursor_q, cursor_n;
	logic [15:0] word_a_q, word_a_n, word_b_q, word_b_n;
	logic [2:0]  flags_q, flags_n;
	logic [7:0]  det_q [3];
	logic [7:0]  det_n [3];
	logic [31:0] wide_q, wide_n, remain_q, remain_n;
	logic        discard_q, discard_n;

	logic        accept;
	logic [7:0]  b;
	logic        last;
	logic [15:0] h_new;
	logic [31:0] product;
	logic [8:0]  count;
	logic [31:0] rem;
	logic [31:0] cur_plus;
	logic [31:0] cur_inc;
	logic [31:0] wide_sh;
	logic [31:0] remain_dec;

	assign stream.ready = space;
	assign accept = stream.valid && space;
	assign b      = stream.byte_value;
	assign last   = stream.last_byte;
	assign h_new   = {height_q[15:8], b};
	assign product = width_q * h_new;
	assign count   = {1'b0, b} + 9'd1;
	assign rem     = total_q - cursor_q;
	assign cur_plus = cursor_q + {23'd0, count};
	assign cur_inc  = cursor_q + 32'd1;
	assign wide_sh  = {wide_q[23:0], b};
	assign remain_dec = (remain_q != 32'd0) ? remain_q - 32'd1 : remain_q;

	always_comb begin
		item_t r0, r1, rec;
		logic  n0, n1, err, complete, adv;
		logic [1:0] ecode;
		phase_n = phase_q; idx_n = idx_q; width_n = width_q; height_n = height_q;
		total_n = total_q; cursor_n = cursor_q; word_a_n = word_a_q; word_b_n = word_b_q;
		flags_n = flags_q; det_n = det_q; wide_n = wide_q; remain_n = remain_q;
		discard_n = discard_q;
		r0 = '0; r1 = '0; n0 = 1'b0; n1 = 1'b0;
		err = 1'b0; ecode = STAT_FORMAT; complete = 1'b0; adv = 1'b0;
		rec = mk_item(KIND_RECORD);
		rec.pos = cursor_q; rec.cnt = 9'd1; rec.fw = word_a_q; rec.flags = flags_q;
		rec.small_v = det_q[0]; rec.fdet = det_q[1]; rec.odet = det_q[2]; rec.wide = wide_q;
		if (discard_q) begin
			if (last) discard_n = 1'b0;
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					if (idx_q == 3'd0) width_n = {b, 8'd0};
					else if (idx_q == 3'd1) width_n = {width_q[15:8], b};
					else if (idx_q == 3'd2) height_n = {b, 8'd0};
					else height_n = h_new;
					if (idx_q < 3'd3) begin
						idx_n = idx_q + 3'd1;
					end else if (width_q == 16'd0 || h_new == 16'd0) begin
						err = 1'b1; ecode = STAT_SIZE;
					end else begin
						total_n = product; cursor_n = '0;
						r0 = mk_item(KIND_HEADER); r0.fw = width_q; r0.sw = h_new; n0 = 1'b1;
						phase_n = PH_FLOOR; idx_n = '0;
					end
				end
				PH_FLOOR: begin
					if (idx_q == 3'd0) word_a_n = {b, 8'd0};
					else if (idx_q == 3'd1) word_a_n = {word_a_q[15:8], b};
					else if (idx_q == 3'd2) word_b_n = {b, 8'd0};
					else if (idx_q == 3'd3) word_b_n = {word_b_q[15:8], b};
					if (idx_q < 3'd4) begin
						idx_n = idx_q + 3'd1;
					end else if ({23'd0, count} > rem) begin
						err = 1'b1;
					end else begin
						r0 = mk_item(KIND_FLOOR); r0.pos = cursor_q; r0.cnt = count;
						r0.fw = word_a_q; r0.sw = word_b_q; n0 = 1'b1;
						idx_n = '0;
						if (cur_plus == total_q) begin
							cursor_n = '0; phase_n = PH_BHEAD;
						end else cursor_n = cur_plus;
					end
				end
				PH_BHEAD: begin
					if (idx_q == 3'd0) begin
						word_a_n = {b, 8'd0}; idx_n = 3'd1;
					end else if (idx_q == 3'd1) begin
						word_a_n = {word_a_q[15:8], b}; idx_n = 3'd2;
					end else if ((b & ~FLAG_ALLOWED) != 8'd0) begin
						err = 1'b1;
					end else begin
						flags_n = b[2:0];
						det_n = '{default: 8'd0}; wide_n = '0; idx_n = '0;
						if (b[2]) phase_n = PH_DETAIL;
						else if (b[0]) begin
							r0 = mk_item(KIND_RECORD); r0.pos = cursor_q; r0.cnt = 9'd1;
							r0.fw = word_a_q; r0.flags = b[2:0]; n0 = 1'b1;
							phase_n = PH_CENTER;
						end else phase_n = PH_COUNT;
					end
				end
				PH_DETAIL: begin
					if (idx_q < 3'd3) det_n[idx_q[1:0]] = b;
					else wide_n = wide_sh;
					if (idx_q < 3'd6) begin
						idx_n = idx_q + 3'd1;
					end else begin
						r0 = rec; r0.wide = wide_sh; n0 = 1'b1;
						idx_n = '0;
						if (flags_q[0]) phase_n = PH_CENTER;
						else adv = 1'b1;
					end
				end
				PH_CENTER: begin
					if (b == 8'd0) begin
						r0 = mk_item(KIND_ESTART); r0.pos = cursor_q; n0 = 1'b1;
						adv = 1'b1;
					end else begin
						wide_n = '0; idx_n = '0; phase_n = PH_ELEN;
					end
				end
				PH_ELEN: begin
					wide_n = wide_sh;
					if (idx_q < 3'd3) begin
						idx_n = idx_q + 3'd1;
					end else begin
						r0 = mk_item(KIND_ESTART); r0.pos = cursor_q; r0.wide = wide_sh;
						r0.center = 1'b1; n0 = 1'b1;
						remain_n = wide_sh; idx_n = '0;
						if (wide_sh == 32'd0) adv = 1'b1;
						else phase_n = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					r0 = mk_item(KIND_EBYTE); r0.pos = cursor_q; r0.small_v = b; n0 = 1'b1;
					remain_n = remain_dec;
					if (remain_dec == 32'd0) adv = 1'b1;
				end
				PH_COUNT: begin
					if ({23'd0, count} > rem) begin
						err = 1'b1;
					end else begin
						r0 = rec; r0.cnt = count; n0 = 1'b1;
						cursor_n = cur_plus; idx_n = '0;
						if (cur_plus == total_q) complete = 1'b1;
						else phase_n = PH_BHEAD;
					end
				end
				default: err = 1'b1;
			endcase
			if (adv) begin
				cursor_n = cur_inc; idx_n = '0;
				if (cur_inc == total_q) complete = 1'b1;
				else phase_n = PH_BHEAD;
			end
			if (err || (complete && last) || (!complete && last)) begin
				phase_n = PH_HEADER; idx_n = '0; width_n = '0; height_n = '0;
				total_n = '0; cursor_n = '0; word_a_n = '0; word_b_n = '0; flags_n = '0;
				det_n = '{default: 8'd0}; wide_n = '0; remain_n = '0;
			end
			priority if (err) begin
				r0 = mk_item(KIND_END); r0.status = ecode; n0 = 1'b1;
				discard_n = !last;
			end else if (last) begin
				// end item follows whatever this byte produced
				if (n0) begin
					r1 = mk_item(KIND_END); r1.status = complete ? STAT_OK : STAT_FORMAT;
					n1 = 1'b1;
				end else begin
					r0 = mk_item(KIND_END); r0.status = complete ? STAT_OK : STAT_FORMAT;
					n0 = 1'b1;
				end
			end else if (complete) begin
				phase_n = PH_DONE;
			end
		end
		ev.two = n1; ev.r0 = r0; ev.r1 = r1;
		ev_push = accept && n0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; idx_q <= '0; width_q <= '0; height_q <= '0;
			total_q <= '0; cursor_q <= '0; word_a_q <= '0; word_b_q <= '0;
			flags_q <= '0; det_q <= '{default: 8'd0}; wide_q <= '0; remain_q <= '0;
			discard_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n; idx_q <= idx_n; width_q <= width_n; height_q <= height_n;
			total_q <= total_n; cursor_q <= cursor_n; word_a_q <= word_a_n;
			word_b_q <= word_b_n; flags_q <= flags_n; det_q <= det_n; wide_q <= wide_n;
			remain_q <= remain_n; discard_q <= discard_n;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/tmrld_queue.sv
// Short event queue between parser and output stage.
`default_nettype none
module tmrld_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tmrld_pkg::event_t wr_ev,
	input  wire logic             push,
	output logic                  space,
	output tmrld_pkg::event_t     head,
	output logic                  head_valid,
	input  wire logic             pop
);
	import tmrld_pkg::*;

	event_t            mem_q [QDepth];
	logic [QPtrW-1:0]  wr_q, rd_q;
	logic [QPtrW:0]    cnt_q;

	assign space      = cnt_q != (QPtrW+1)'(QDepth);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPtrW+1)'(QDepth)) else $error("queue count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> space) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> rtl/core/tmrld_back.sv
// Output stage: delivers the one or two results of each queued event.
`default_nettype none
module tmrld_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tmrld_pkg::event_t head,
	input  wire logic              head_valid,
	output logic                   pop,
	tmrld_out_if.source            items
);
	import tmrld_pkg::*;

	logic  sel_q;
	logic  fire;
	item_t cur;

	assign cur   = sel_q ? head.r1 : head.r0;
	assign fire  = items.valid && items.ready;
	assign pop   = fire && (sel_q || !head.two);

	assign items.valid          = head_valid;
	assign items.record_kind    = cur.kind;
	assign items.tile_position  = cur.pos;
	assign items.run_count      = cur.cnt;
	assign items.first_word     = cur.fw;
	assign items.second_word    = cur.sw;
	assign items.tile_flags     = cur.flags;
	assign items.small_value    = cur.small_v;
	assign items.floor_detail   = cur.fdet;
	assign items.overlay_detail = cur.odet;
	assign items.wide_value     = cur.wide;
	assign items.entity_marked  = cur.center;
	assign items.frame_status   = cur.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sel_q <= 1'b0;
		else if (fire) sel_q <= !pop;
	end

endmodule
`default_nettype wire

>>> rtl/core/tile_map_run_length_decoder_core.sv
// Top level of the tile-map run-length decoder.
// A byte's results are written into the event queue and offered from its head.
// Throughput: 1 byte per cycle while the event queue has space; a byte that yields two
// results takes two output transactions, and the 4-entry event queue absorbs such bursts.
// The 16x16 size multiply runs in the header byte's cycle, stored as total tiles.
// Reset (arst_n low, asynchronous): parser to header phase, queue empty.
`default_nettype none
module tile_map_run_length_decoder_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tmrld_in_if.sink    stream,
	tmrld_out_if.source items
);
	import tmrld_pkg::*;

	// front: parse bytes into events of one or two result transactions
	event_t ev;
	logic   ev_push;
	logic   space;
	// back: drain events onto the result channel
	event_t head;
	logic   head_valid;
	logic   pop;

	tmrld_front u_front (
		.clk, .arst_n, .stream, .space, .ev, .ev_push
	);

	tmrld_queue u_queue (
		.clk, .arst_n, .wr_ev(ev), .push(ev_push), .space,
		.head, .head_valid, .pop
	);

	tmrld_back u_back (
		.clk, .arst_n, .head, .head_valid, .pop, .items
	);

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid |-> items.record_kind <= KIND_END) else $error("bad result kind");
	a_status_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.record_kind != KIND_END |-> items.frame_status == STAT_OK)
		else $error("status outside end item");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && !items.ready |=> items.valid) else $error("result dropped");

endmodule
`default_nettype wire

>>> test/decoder_checker.sv
// Checker for the tile-map decoder: predicts results per byte and compares them.
module decoder_checker (
	input  logic        clk,
	input  logic        arst_n,
	tmrld_in_if         stream,
	tmrld_out_if        items,
	output int          mismatches,
	output int          pending
);
	import tmrld_pkg::*;

	item_t       expected_items[$];

	// decoder state mirror
	logic [3:0]  phase;
	logic [2:0]  idx;
	logic [15:0] map_w, map_h, word_a, word_b;
	logic [31:0] total, cursor, acc, payload_left;
	logic [2:0]  flags;
	logic [7:0]  det [3];
	logic        discard;

	task automatic clear_frame();
		phase = PH_HEADER;
		idx = '0;
		map_w = '0;
		map_h = '0;
		total = '0;
		cursor = '0;
		word_a = '0;
		word_b = '0;
		flags = '0;
		det[0] = '0;
		det[1] = '0;
		det[2] = '0;
		acc = '0;
		payload_left = '0;
	endtask

	function automatic item_t blank(input logic [2:0] kind);
		item_t it;
		it = '0;
		it.kind = kind;
		return it;
	endfunction

	function automatic item_t block_record(input logic [31:0] run);
		item_t it;
		it = blank(KIND_RECORD);
		it.pos = cursor;
		it.cnt = run[8:0];
		it.fw = word_a;
		it.flags = flags;
		it.small_v = det[0];
		it.fdet = det[1];
		it.odet = det[2];
		it.wide = acc;
		return it;
	endfunction

	// finish one flagged tile; returns 1 when the map is fully covered
	function automatic bit next_tile();
		cursor = cursor + 1;
		idx = '0;
		if (cursor == total)
			return 1'b1;
		phase = PH_BHEAD;
		return 1'b0;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic last);
		item_t       res[$];
		item_t       it;
		int          err;
		bit          complete;
		logic [31:0] count, rem;
		logic [2:0]  ix;
		err = -1;
		complete = 0;
		ix = idx;
		if (discard) begin
			if (last)
				discard = 0;
			return;
		end
		case (phase)
			PH_HEADER: begin
				case (ix)
					3'd0: map_w = {b, 8'h00};
					3'd1: map_w[7:0] = b;
					3'd2: map_h = {b, 8'h00};
					default: map_h[7:0] = b;
				endcase
				if (ix < 3)
					idx = ix + 1;
				else if (map_w == 0 || map_h == 0)
					err = STAT_SIZE;
				else begin
					total = {16'h0, map_w} * {16'h0, map_h};
					cursor = '0;
					it = blank(KIND_HEADER);
					it.fw = map_w;
					it.sw = map_h;
					res.push_back(it);
					phase = PH_FLOOR;
					idx = '0;
				end
			end
			PH_FLOOR: begin
				case (ix)
					3'd0: word_a = {b, 8'h00};
					3'd1: word_a[7:0] = b;
					3'd2: word_b = {b, 8'h00};
					3'd3: word_b[7:0] = b;
					default: ;
				endcase
				if (ix < 4)
					idx = ix + 1;
				else begin
					count = {24'h0, b} + 1;
					rem = total - cursor;
					if (count > rem)
						err = STAT_FORMAT;
					else begin
						it = blank(KIND_FLOOR);
						it.pos = cursor;
						it.cnt = count[8:0];
						it.fw = word_a;
						it.sw = word_b;
						res.push_back(it);
						cursor = cursor + count;
						idx = '0;
						if (cursor == total) begin
							cursor = '0;
							phase = PH_BHEAD;
						end
					end
				end
			end
			PH_BHEAD: begin
				if (ix == 0) begin
					word_a = {b, 8'h00};
					idx = 1;
				end else if (ix == 1) begin
					word_a[7:0] = b;
					idx = 2;
				end else if ((b & ~FLAG_ALLOWED) != 0)
					err = STAT_FORMAT;
				else begin
					flags = b[2:0];
					det[0] = '0;
					det[1] = '0;
					det[2] = '0;
					acc = '0;
					idx = '0;
					if (flags[2])
						phase = PH_DETAIL;
					else if (flags[0]) begin
						res.push_back(block_record(1));
						phase = PH_CENTER;
					end else
						phase = PH_COUNT;
				end
			end
			PH_DETAIL: begin
				if (ix < 3)
					det[ix] = b;
				else
					acc = {acc[23:0], b};
				if (ix < 6)
					idx = ix + 1;
				else begin
					res.push_back(block_record(1));
					idx = '0;
					if (flags[0])
						phase = PH_CENTER;
					else
						complete = next_tile();
				end
			end
			PH_CENTER: begin
				if (b == 0) begin
					it = blank(KIND_ESTART);
					it.pos = cursor;
					res.push_back(it);
					complete = next_tile();
				end else begin
					acc = '0;
					idx = '0;
					phase = PH_ELEN;
				end
			end
			PH_ELEN: begin
				acc = {acc[23:0], b};
				if (ix < 3)
					idx = ix + 1;
				else begin
					it = blank(KIND_ESTART);
					it.pos = cursor;
					it.wide = acc;
					it.center = 1'b1;
					res.push_back(it);
					payload_left = acc;
					idx = '0;
					if (payload_left == 0)
						complete = next_tile();
					else
						phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				it = blank(KIND_EBYTE);
				it.pos = cursor;
				it.small_v = b;
				res.push_back(it);
				if (payload_left != 0)
					payload_left = payload_left - 1;
				if (payload_left == 0)
					complete = next_tile();
			end
			PH_COUNT: begin
				count = {24'h0, b} + 1;
				rem = total - cursor;
				if (count > rem)
					err = STAT_FORMAT;
				else begin
					res.push_back(block_record(count));
					cursor = cursor + count;
					idx = '0;
					if (cursor == total)
						complete = 1;
					else
						phase = PH_BHEAD;
				end
			end
			default: err = STAT_FORMAT;
		endcase

		if (err >= 0) begin
			res.delete();
			it = blank(KIND_END);
			it.status = err[1:0];
			res.push_back(it);
			clear_frame();
			if (!last)
				discard = 1;
		end else if (complete) begin
			if (last) begin
				res.push_back(blank(KIND_END));
				clear_frame();
			end else
				phase = PH_DONE;
		end else if (last) begin
			it = blank(KIND_END);
			it.status = STAT_FORMAT;
			res.push_back(it);
			clear_frame();
		end
		foreach (res[k])
			expected_items.push_back(res[k]);
	endtask

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		$display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t e;
		if (!arst_n) begin
			clear_frame();
			discard = 0;
			expected_items.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (stream.valid && stream.ready)
				decode_byte(stream.byte_value, stream.last_byte);
			if (items.valid && items.ready) begin
				if (expected_items.size() == 0)
					report("unexpected result, kind", '0, items.record_kind);
				else begin
					e = expected_items.pop_front();
					if (items.record_kind != e.kind)
						report("record_kind", e.kind, items.record_kind);
					if (items.tile_position != e.pos)
						report("tile_position", e.pos, items.tile_position);
					if (items.run_count != e.cnt)
						report("run_count", e.cnt, items.run_count);
					if (items.first_word != e.fw)
						report("first_word", e.fw, items.first_word);
					if (items.second_word != e.sw)
						report("second_word", e.sw, items.second_word);
					if (items.tile_flags != e.flags)
						report("tile_flags", e.flags, items.tile_flags);
					if (items.small_value != e.small_v)
						report("small_value", e.small_v, items.small_value);
					if (items.floor_detail != e.fdet)
						report("floor_detail", e.fdet, items.floor_detail);
					if (items.overlay_detail != e.odet)
						report("overlay_detail", e.odet, items.overlay_detail);
					if (items.wide_value != e.wide)
						report("wide_value", e.wide, items.wide_value);
					if (items.entity_marked != e.center)
						report("entity_marked", e.center, items.entity_marked);
					if (items.frame_status != e.status)
						report("frame_status", e.status, items.frame_status);
				end
			end
			pending = expected_items.size();
		end
	end

endmodule

>>> test/testbench.sv
// Stimulus and verdict for the tile-map run-length decoder.
module testbench;
	import tmrld_pkg::*;

	localparam int StallLimit = 3000;  // cycles with no transaction on either side
	localparam int HoldCycles = 300;   // long receiver hold-off

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   hold_req;
	bit   hold_taken;
	int   quiet_cycles;
	logic [8:0] stim_bytes[$];  // {last, byte}

	tmrld_in_if  stream ();
	tmrld_out_if items ();

	tile_map_run_length_decoder_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.stream(stream),
		.items (items)
	);

	decoder_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream),
		.items     (items),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: random stalls, plus one long hold-off counted here
	initial begin
		items.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1;
				items.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end
			items.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog: give up when the pipe stops moving
	always @(posedge clk) begin
		if ((stream.valid && stream.ready) || (items.valid && items.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic put(input logic [7:0] b, input bit last = 0);
		stim_bytes.push_back({last, b});
	endtask

	task automatic put16(input logic [15:0] w);
		put(w[15:8]);
		put(w[7:0]);
	endtask

	// Builds one map frame: well formed, or broken in one of several ways.
	task automatic build_frame();
		logic [7:0]  frame[$];
		logic [31:0] n_tiles, covered, len;
		logic [2:0]  fl;
		int          w, h, c, flaw, pos;
		w = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 3);
		h = $urandom_range(1, 3);
		n_tiles = w * h;
		frame = {w[15:8], w[7:0], h[15:8], h[7:0]};
		covered = 0;
		while (covered < n_tiles) begin
			c = $urandom_range(1, n_tiles - covered);
			frame.push_back($urandom_range(255));
			frame.push_back($urandom_range(255));
			frame.push_back($urandom_range(255));
			frame.push_back($urandom_range(255));
			frame.push_back(c - 1);
			covered += c;
		end
		covered = 0;
		while (covered < n_tiles) begin
			frame.push_back($urandom_range(255));
			frame.push_back($urandom_range(255));
			case ($urandom_range(3))
				0: fl = 3'd0;
				1: fl = 3'd1;
				2: fl = 3'd4;
				default: fl = 3'd5;
			endcase
			frame.push_back(fl);
			if (fl == 0) begin
				c = $urandom_range(1, n_tiles - covered);
				frame.push_back(c - 1);
				covered += c;
			end else begin
				if (fl[2])
					repeat (7) frame.push_back($urandom_range(255));
				if (fl[0]) begin
					if ($urandom_range(2) == 0)
						frame.push_back(8'h00);
					else begin
						frame.push_back($urandom_range(1, 255));
						len = $urandom_range(3);
						frame.push_back(len[31:24]);
						frame.push_back(len[23:16]);
						frame.push_back(len[15:8]);
						frame.push_back(len[7:0]);
						repeat (len) frame.push_back($urandom_range(255));
					end
				end
				covered += 1;
			end
		end
		flaw = $urandom_range(9);
		pos = $urandom_range(frame.size() - 1);
		if (flaw == 0)
			frame = frame[0:pos];                      // truncated
		else if (flaw == 1)
			frame[pos] = $urandom_range(255);          // damaged byte
		else if (flaw == 2)
			repeat ($urandom_range(1, 3)) frame.push_back($urandom_range(255));  // trailing
		else if (flaw == 3) begin
			frame.delete();                            // noise
			repeat ($urandom_range(1, 12)) frame.push_back($urandom_range(255));
		end
		foreach (frame[k])
			put(frame[k], k == frame.size() - 1);
	endtask

	task automatic send_all();
		logic [8:0] t;
		while (stim_bytes.size() != 0) begin
			t = stim_bytes.pop_front();
			if ($urandom_range(99) < send_idle_pct) begin
				stream.valid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			stream.valid <= 1'b1;
			stream.byte_value <= t[7:0];
			stream.last_byte <= t[8];
			do @(posedge clk); while (!stream.ready);
		end
		stream.valid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int s_pct, input int r_pct, input bit hold);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		while (stim_bytes.size() < 200)
			build_frame();
		if (hold)
			hold_req = 1;
		send_all();
		drain();   // sender pauses until every result is back
	endtask

	initial begin
		arst_n = 1'b0;
		hold_req = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stream.valid <= 1'b0;
		stream.byte_value <= '0;
		stream.last_byte <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// largest map, longest floor run, then cut short
		put16(16'hFFFF); put16(16'hFFFF);
		put16(16'hFF00); put16(16'h00FF); put(8'hFF, 1);
		// zero size not on last byte: rest of buffer dropped
		put16(16'h0001); put16(16'h0000); put(8'h5A); put(8'hA5, 1);
		// 1x1 map, bad flag byte
		put16(16'h0001); put16(16'h0001); put16(16'h0000); put16(16'h0000); put(8'h00);
		put16(16'h1234); put(8'hFA, 1);
		// 1x1 map, entity with huge length, truncated in payload
		put16(16'h0001); put16(16'h0001); put16(16'hABCD); put16(16'h0102); put(8'h00);
		put16(16'hFFFF); put(8'h01); put(8'h80);
		put16(16'hFFFF); put16(16'hFFFF); put(8'h7E, 1);
		// overrun floor run
		put16(16'h0001); put16(16'h0002); put16(16'h0000); put16(16'h0000); put(8'h05, 1);
		send_all();
		drain();

		random_phase(16, 78, 0);
		random_phase(78, 16, 0);
		random_phase(0, 0, 1);   // receiver holds off while bytes keep coming

		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
